@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of this block.
// All checks are clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a sequence property holds at every clock edge.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a plain expression is true at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

@@ rtl/core/lsir_pkg.sv @@
// ----------------------------------------------------------------------------
// lsir_pkg
// Shared types and constants for the indexed LIFO stack: stack geometry,
// command and status codes, transaction structs and cell control.
// ----------------------------------------------------------------------------
package lsir_pkg;

    // Stack geometry
    localparam int unsigned DEPTH      = 16;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the transactions
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned ENTRY_W = 5;

    // Width used for position/count compares
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_READ   = 2'd2,
        CMD_REMOVE = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        command_t           command;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   result_value;
        logic [ENTRY_W-1:0] entry_count;
    } rsp_t;

    // Per-cell move: hold, take from the cell above (push), take from below
    typedef enum logic [1:0] {
        CELL_HOLD = 2'b00,
        CELL_PUSH = 2'b01,
        CELL_PULL = 2'b10
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     read_sel;
    } cell_ctl_t;

endpackage

@@ rtl/core/lsir_cell.sv @@
// ----------------------------------------------------------------------------
// lsir_cell
// One stack slot. Holds a word, loads it from the neighbor nearer the top
// on a push or from the neighbor further down on a pop/remove, and drives
// its word onto the read tap when selected.
// ----------------------------------------------------------------------------
module lsir_cell (
    input  logic                            clk,
    input  lsir_pkg::cell_ctl_t             ctl,
    input  logic [lsir_pkg::DATA_WIDTH-1:0] upper,
    input  logic [lsir_pkg::DATA_WIDTH-1:0] lower,
    output logic [lsir_pkg::DATA_WIDTH-1:0] data,
    output logic [lsir_pkg::DATA_WIDTH-1:0] tap
);

    logic [lsir_pkg::DATA_WIDTH-1:0] data_reg;
    logic [lsir_pkg::DATA_WIDTH-1:0] data_next;

    // Neighbor select
    always_comb
    begin
        unique case (ctl.op)
            lsir_pkg::CELL_PUSH: data_next = upper;
            lsir_pkg::CELL_PULL: data_next = lower;
            lsir_pkg::CELL_HOLD: data_next = data_reg;
            default:             data_next = data_reg;
        endcase
    end

    // Slot storage, payload only
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = ctl.read_sel ? data_reg : '0;

endmodule

@@ rtl/core/lifo_stack_indexed_remove.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_indexed_remove
// Bounded LIFO stack with push, pop, indexed read and indexed remove,
// built as a row of slot cells with the top of stack in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one command per
//   transaction: push, pop, read nth from top or remove nth from top.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
//   command: status, the word popped/read/removed (zero unless ok) and the
//   entry count after the command.
// Latency: the response is valid on the cycle after the command is taken.
// Throughput: one command per cycle while rsp_ready is high. Every cell
//   shifts or holds at the same clock edge, so a push, pop or middle
//   removal completes at that edge; the count register is the only state
//   the next command's decode depends on.
// Stall: a single response register sits on the output. While it is full
//   and rsp_ready is low, cmd_ready is low and the stack holds still; a
//   new command is taken in the same cycle the pending response leaves.
// Reset: rst_n clears the entry count and the response valid. Slot
//   contents are not cleared; slots at or above the count are never read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_indexed_remove (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  lsir_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lsir_pkg::rsp_t rsp
);

    localparam int unsigned DEPTH = lsir_pkg::DEPTH;
    localparam int unsigned DW    = lsir_pkg::DATA_WIDTH;
    localparam int unsigned CNT_W = lsir_pkg::CNT_W;
    localparam int unsigned CMP_W = lsir_pkg::CMP_W;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    lsir_pkg::rsp_t           rsp_reg;
    lsir_pkg::rsp_t           rsp_next;

    logic                     cmd_fire;
    logic                     is_full;
    logic                     is_empty;
    logic                     is_pop;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         eff_pos;
    lsir_pkg::status_t        status;
    logic                     do_push;
    logic                     do_pull;
    logic                     found;
    logic [DW-1:0]            read_data;

    lsir_pkg::cell_ctl_t      cell_ctl  [DEPTH];
    logic [DW-1:0]            cell_data [DEPTH];
    logic [DW-1:0]            cell_tap  [DEPTH];

    // Handshake: one response register decouples the two sides
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Command decode
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign is_pop   = (cmd.command == lsir_pkg::CMD_POP);
    assign pos_ext  = CMP_W'(cmd.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign eff_pos  = is_pop ? CMP_W'(1) : pos_ext;

    always_comb
    begin
        status  = lsir_pkg::ST_OK;
        do_push = 1'b0;
        do_pull = 1'b0;
        found   = 1'b0;
        unique case (cmd.command) inside
            lsir_pkg::CMD_PUSH:
            begin
                if (is_full)
                    status = lsir_pkg::ST_FULL;
                else
                    do_push = 1'b1;
            end
            lsir_pkg::CMD_POP, lsir_pkg::CMD_READ, lsir_pkg::CMD_REMOVE:
            begin
                if (is_empty)
                    status = lsir_pkg::ST_EMPTY;
                else if (!is_pop && (pos_ext == '0 || pos_ext > cnt_ext))
                    status = lsir_pkg::ST_RANGE;
                else
                begin
                    found   = 1'b1;
                    do_pull = (cmd.command != lsir_pkg::CMD_READ);
                end
            end
            default:
            begin
                status = lsir_pkg::ST_OK;
            end
        endcase
    end

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + CNT_W'(1);
        else if (do_pull)
            count_next = count_reg - CNT_W'(1);
    end

    // Row of cells, top of stack in cell 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] upper;
        logic [DW-1:0] lower;

        if (i == 0)
        begin : g_top
            assign upper = DW'(cmd.value);
        end
        else
        begin : g_mid_up
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_mid_dn
            assign lower = cell_data[i+1];
        end

        // Push shifts every cell down; removal pulls up from the hit slot on
        always_comb
        begin
            cell_ctl[i].read_sel = (CMP_W'(i + 1) == eff_pos);
            if (cmd_fire && do_push)
                cell_ctl[i].op = lsir_pkg::CELL_PUSH;
            else if (cmd_fire && do_pull && (CMP_W'(i + 1) >= eff_pos))
                cell_ctl[i].op = lsir_pkg::CELL_PULL;
            else
                cell_ctl[i].op = lsir_pkg::CELL_HOLD;
        end

        lsir_cell u_cell (
            .clk   (clk),
            .ctl   (cell_ctl[i]),
            .upper (upper),
            .lower (lower),
            .data  (cell_data[i]),
            .tap   (cell_tap[i])
        );
    end

    // Gather the selected slot
    always_comb
    begin
        read_data = '0;
        for (int k = 0; k < DEPTH; k++)
            read_data = read_data | cell_tap[k];
    end

    // Response build
    always_comb
    begin
        rsp_next.status       = status;
        rsp_next.result_value = found ? lsir_pkg::VAL_W'(read_data) : '0;
        rsp_next.entry_count  = lsir_pkg::ENTRY_W'(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            rsp_reg <= rsp_next;
    end

    // Checks
    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `ASSERT_PROP(a_fire_gives_rsp, cmd_fire |=> rsp_valid_reg, "command without response")
    `ASSERT_PROP(a_count_hold, !cmd_fire |=> $stable(count_reg), "count moved with no command")
    `ASSERT_ALWAYS(a_rsp_count, !rsp_valid_reg || rsp_reg.entry_count == lsir_pkg::ENTRY_W'(count_reg), "response count differs from stack count")
    `ASSERT_ALWAYS(a_err_zero, !rsp_valid_reg || rsp_reg.status == lsir_pkg::ST_OK || rsp_reg.result_value == '0, "error response carries data")

endmodule

@@ verif/tb_lifo_stack_indexed_remove.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_indexed_remove
// Self-checking bench for the indexed LIFO stack. A shadow stack predicts
// the response to every command taken on the cmd channel. Each response
// taken on the rsp channel is checked field by field against the oldest
// prediction. Directed tests cover the empty and full stack and the
// position edges. Random traffic then swings the fill level between empty
// and full, with random gaps on cmd_valid and random stalls on rsp_ready.
// ----------------------------------------------------------------------------
module tb_lifo_stack_indexed_remove;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PCT       = 31;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_ready;
    lsir_pkg::cmd_t cmd;
    logic           rsp_valid;
    logic           rsp_ready;
    lsir_pkg::rsp_t rsp;

    // Shadow copy of the stack: index 0 is the bottom
    logic [lsir_pkg::DATA_WIDTH-1:0] shadow_words [lsir_pkg::DEPTH];
    int unsigned                     shadow_fill;

    lsir_pkg::rsp_t expected_replies [$];
    int             error_count;
    bit             steady_mode;
    int             cmds_seen [4];
    int             status_seen [4];

    lifo_stack_indexed_remove u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Apply one command to the shadow stack and return its response
    function automatic lsir_pkg::rsp_t apply_stack_cmd(lsir_pkg::cmd_t c);
        lsir_pkg::rsp_t r;
        int unsigned    slot;
        r.status       = lsir_pkg::ST_OK;
        r.result_value = '0;
        if (c.command == lsir_pkg::CMD_PUSH)
        begin
            if (shadow_fill >= lsir_pkg::DEPTH)
                r.status = lsir_pkg::ST_FULL;
            else
            begin
                shadow_words[shadow_fill] = c.value[lsir_pkg::DATA_WIDTH-1:0];
                shadow_fill++;
            end
        end
        else if (shadow_fill == 0)
            r.status = lsir_pkg::ST_EMPTY;
        else if (c.command != lsir_pkg::CMD_POP &&
                 (c.position == 0 || c.position > shadow_fill))
            r.status = lsir_pkg::ST_RANGE;
        else
        begin
            slot = (c.command == lsir_pkg::CMD_POP) ? shadow_fill - 1
                                                    : shadow_fill - c.position;
            r.result_value = lsir_pkg::VAL_W'(shadow_words[slot]);
            // pop and remove close the gap
            if (c.command != lsir_pkg::CMD_READ)
            begin
                for (int k = slot; k + 1 < shadow_fill; k++)
                    shadow_words[k] = shadow_words[k + 1];
                shadow_fill--;
            end
        end
        r.entry_count = lsir_pkg::ENTRY_W'(shadow_fill);
        return r;
    endfunction

    // Send one command transaction; called at a rising edge
    task automatic send_cmd(lsir_pkg::command_t op, logic [lsir_pkg::VAL_W-1:0] word,
                            logic [lsir_pkg::POS_W-1:0] pos);
        lsir_pkg::cmd_t item;
        bit             taken;
        item.command  = op;
        item.value    = word;
        item.position = pos;
        if (!steady_mode && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        cmd_valid <= 1'b1;
        cmd       <= item;
        // inputs are stable by the falling edge, so sample the handshake there
        do
        begin
            @(negedge clk);
            taken = cmd_ready;
            @(posedge clk);
        end
        while (!taken);
        expected_replies.push_back(apply_stack_cmd(item));
        cmds_seen[int'(op)]++;
    endtask

    // Response side: random stalls unless in steady mode
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Response checker
    initial
    begin : reply_checker
        lsir_pkg::rsp_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected response: expected none, actual %h", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    status_seen[int'(want.status)]++;
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.result_value !== want.result_value)
                    begin
                        $display("%0t: result_value mismatch: expected %h, actual %h",
                                 $time, want.result_value, rsp.result_value);
                        error_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: stop if no transaction moves on either channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("lifo_stack_indexed_remove test failed");
        $finish;
    end

    // Pop, read and remove on an empty stack, position ignored
    task automatic test_empty_stack();
        send_cmd(lsir_pkg::CMD_POP, 32'hFFFF_FFFF, 5'd1);
        send_cmd(lsir_pkg::CMD_READ, 32'h0000_0000, 5'd31);
        send_cmd(lsir_pkg::CMD_REMOVE, 32'h1234_5678, 5'd0);
    endtask

    // Fill to capacity, starting with boundary words, then push once more
    task automatic test_fill_and_overflow();
        logic [lsir_pkg::VAL_W-1:0] word;
        for (int i = 0; i < lsir_pkg::DEPTH; i++)
        begin
            case (i)
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'hAAAA_AAAA;
                3:       word = 32'h5555_5555;
                default: word = $urandom;
            endcase
            send_cmd(lsir_pkg::CMD_PUSH, word, lsir_pkg::POS_W'(i));
        end
        send_cmd(lsir_pkg::CMD_PUSH, 32'hDEAD_BEEF, 5'd0);
    endtask

    // Position zero, past the count, bottom, top and middle
    task automatic test_position_edges();
        send_cmd(lsir_pkg::CMD_READ, '0, 5'd0);
        send_cmd(lsir_pkg::CMD_READ, '0, lsir_pkg::POS_W'(lsir_pkg::DEPTH + 1));
        send_cmd(lsir_pkg::CMD_READ, '0, lsir_pkg::POS_W'(lsir_pkg::DEPTH));
        send_cmd(lsir_pkg::CMD_REMOVE, '0, lsir_pkg::POS_W'(lsir_pkg::DEPTH));
        send_cmd(lsir_pkg::CMD_REMOVE, '1, 5'd1);
        send_cmd(lsir_pkg::CMD_REMOVE, '0, 5'd7);
        send_cmd(lsir_pkg::CMD_READ, '0, 5'd1);
    endtask

    // Random traffic that drifts between empty and full
    task automatic run_random_traffic(int n_items);
        bit                         growing;
        lsir_pkg::command_t         op;
        logic [lsir_pkg::POS_W-1:0] pos;
        logic [lsir_pkg::VAL_W-1:0] word;
        growing = 1'b1;
        repeat (n_items)
        begin
            if (shadow_fill == lsir_pkg::DEPTH)
                growing = 1'b0;
            else if (shadow_fill == 0)
                growing = 1'b1;
            if ($urandom_range(99) < (growing ? 60 : 20))
                op = lsir_pkg::CMD_PUSH;
            else
                op = lsir_pkg::command_t'($urandom_range(1, 3));
            // mostly legal positions, some anything the field holds
            if (shadow_fill > 0 && $urandom_range(99) < 85)
                pos = lsir_pkg::POS_W'($urandom_range(1, shadow_fill));
            else
                pos = lsir_pkg::POS_W'($urandom_range(0, 31));
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            send_cmd(op, word, pos);
        end
    endtask

    // Back-to-back transactions with no gaps and no stalls
    task automatic test_steady_stream();
        steady_mode = 1'b1;
        run_random_traffic(250);
        steady_mode = 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        shadow_fill = 0;
        error_count = 0;
        steady_mode = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_fill_and_overflow();
        test_position_edges();
        run_random_traffic(1100);
        test_steady_stream();
        cmd_valid <= 1'b0;

        // drain outstanding responses
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Commands: %0d push, %0d pop, %0d read, %0d remove",
                 cmds_seen[0], cmds_seen[1], cmds_seen[2], cmds_seen[3]);
        $display("Responses: %0d ok, %0d empty, %0d out of range, %0d full",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0)
            $display("lifo_stack_indexed_remove test passed");
        else
            $display("lifo_stack_indexed_remove test failed");
        $finish;
    end

endmodule
